// ===== design/soundex_encoder_core_macros.svh =====
`ifndef SOUNDEX_ENCODER_CORE_MACROS_SVH
`define SOUNDEX_ENCODER_CORE_MACROS_SVH

// same-cycle implication on the rising edge of clk
`define SND_ASSERT_IMP(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the rising edge of clk
`define SND_ASSERT_NXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/snd_pkg.sv =====
`default_nettype none

package snd_pkg;

  localparam int unsigned GROUPS   = 7;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned VALUE_W  = 14;
  localparam int unsigned LETTER_W = 7;
  localparam int unsigned DIGIT_W  = 3;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned DIGITS   = 3;
  localparam int unsigned COUNT_W  = 2;
  localparam int unsigned OUT_W    = 32;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

  localparam logic [VALUE_W-1:0] WEIGHT_LETTER = VALUE_W'(GROUPS * GROUPS * GROUPS);
  localparam logic [VALUE_W-1:0] WEIGHT_ONE    = VALUE_W'(GROUPS * GROUPS);
  localparam logic [VALUE_W-1:0] WEIGHT_TWO    = VALUE_W'(GROUPS);

  typedef logic [DIGIT_W-1:0] code_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef struct packed {
    logic [OUT_W-VALUE_W-LETTER_W-3*DIGIT_W-1:0] pad;
    code_t                                       digit_three;
    code_t                                       digit_two;
    code_t                                       digit_one;
    logic [LETTER_W-1:0]                         first_letter;
    logic [VALUE_W-1:0]                          soundex_value;
  } result_t;

  function automatic code_t group_of(input index_t idx);
    code_t code;
    case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                             code = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = 3'd2;
      5'd3, 5'd19:                                          code = 3'd3;
      5'd11:                                                code = 3'd4;
      5'd12, 5'd13:                                         code = 3'd5;
      5'd17:                                                code = 3'd6;
      default:                                              code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/soundex_encoder_core.sv =====
`default_nettype none

// Soundex encoder: takes a name one ASCII byte per item on s_axis (tlast marks the
// end-of-name item, whose byte is ignored) and returns one 32-bit result item on m_axis
// per end-of-name item. Each item sits in the input register, where the group lookup and
// state update happen; an end-of-name item then lands in the result register, from which
// its result is driven onto m_axis. One item is taken every cycle; the only stall comes
// from a result still waiting in the result register when the next end-of-name item
// reaches the input register.
module soundex_encoder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [snd_pkg::CHAR_W-1:0]     s_axis_tdata,   // [7:0] character
  input  logic                           s_axis_tlast,   // end_of_name
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [snd_pkg::OUT_W-1:0]      m_axis_tdata    // [13:0] soundex_value,
                                                         // [20:14] first_letter,
                                                         // [23:21] digit_one,
                                                         // [26:24] digit_two,
                                                         // [29:27] digit_three, [31:30] 0
);
  import snd_pkg::*;

  logic                in_valid;
  logic [CHAR_W-1:0]   in_char;
  logic                in_last;
  logic                in_advance;

  logic                letter_seen, letter_seen_next;
  index_t              leading_letter, leading_letter_next;
  code_t               previous_code, previous_code_next;
  logic [COUNT_W-1:0]  digit_count, digit_count_next;
  code_t               code_digits [DIGITS];
  code_t               code_digits_next [DIGITS];

  logic                is_upper, is_lower, is_letter;
  index_t              idx;
  code_t               code;
  result_t             result_next;

  assign in_advance    = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_advance;

  assign is_upper  = (in_char >= ASCII_UPPER_A) && (in_char <= ASCII_UPPER_Z);
  assign is_lower  = (in_char >= ASCII_LOWER_A) && (in_char <= ASCII_LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign idx       = is_upper ? INDEX_W'(in_char - ASCII_UPPER_A)
                              : INDEX_W'(in_char - ASCII_LOWER_A);
  assign code      = group_of(idx);

  always_comb begin
    letter_seen_next    = letter_seen;
    leading_letter_next = leading_letter;
    previous_code_next  = previous_code;
    digit_count_next    = digit_count;
    for (int i = 0; i < DIGITS; i++) begin
      code_digits_next[i] = code_digits[i];
    end
    if (in_last) begin
      letter_seen_next    = 1'b0;
      leading_letter_next = '0;
      previous_code_next  = '0;
      digit_count_next    = '0;
      for (int i = 0; i < DIGITS; i++) begin
        code_digits_next[i] = '0;
      end
    end else if (is_letter) begin
      if (!letter_seen) begin
        letter_seen_next    = 1'b1;
        leading_letter_next = idx;
        previous_code_next  = code;
      end else if (digit_count != COUNT_W'(DIGITS)) begin
        if (code != '0 && code != previous_code) begin
          for (int i = 0; i < DIGITS; i++) begin
            if (digit_count == COUNT_W'(i)) begin
              code_digits_next[i] = code;
            end
          end
          digit_count_next = digit_count + 1'b1;
        end
        previous_code_next = code;
      end
    end
  end

  always_comb begin
    result_next = '0;
    if (letter_seen) begin
      result_next.soundex_value = VALUE_W'(leading_letter) * WEIGHT_LETTER
                                + VALUE_W'(code_digits[0]) * WEIGHT_ONE
                                + VALUE_W'(code_digits[1]) * WEIGHT_TWO
                                + VALUE_W'(code_digits[2]) + VALUE_W'(1);
      result_next.first_letter  = LETTER_W'(CHAR_W'(leading_letter) + ASCII_UPPER_A);
      result_next.digit_one     = code_digits[0];
      result_next.digit_two     = code_digits[1];
      result_next.digit_three   = code_digits[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      letter_seen    <= 1'b0;
      leading_letter <= '0;
      previous_code  <= '0;
      digit_count    <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        code_digits[i] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (in_advance) begin
        letter_seen    <= letter_seen_next;
        leading_letter <= leading_letter_next;
        previous_code  <= previous_code_next;
        digit_count    <= digit_count_next;
        for (int i = 0; i < DIGITS; i++) begin
          code_digits[i] <= code_digits_next[i];
        end
      end
      if (in_advance && in_last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (in_advance && in_last) begin
      m_axis_tdata <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/snd_checker.sv =====
`default_nettype none

`include "soundex_encoder_core_macros.svh"

module snd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [snd_pkg::OUT_W-1:0] m_axis_tdata
);
  import snd_pkg::*;

  result_t res;
  logic    digits_ok;
  logic    letter_ok;

  assign res       = m_axis_tdata;
  assign digits_ok = (res.digit_one <= 3'd6) && (res.digit_two <= 3'd6)
                  && (res.digit_three <= 3'd6);
  assign letter_ok = (CHAR_W'(res.first_letter) >= ASCII_UPPER_A)
                  && (CHAR_W'(res.first_letter) <= ASCII_UPPER_Z);

  `SND_ASSERT_NXT(a_reset_idle, 1'b0, rst, !m_axis_tvalid && s_axis_tready,
    "result valid or input stalled right after reset")

  `SND_ASSERT_NXT(a_out_hold, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")

  `SND_ASSERT_IMP(a_empty_name, rst, m_axis_tvalid && res.soundex_value == '0,
    res.first_letter == '0 && res.digit_one == '0 && res.digit_two == '0
    && res.digit_three == '0 && res.pad == '0, "empty-name result has nonzero fields")

  `SND_ASSERT_IMP(a_code_fields, rst, m_axis_tvalid && res.soundex_value != '0,
    letter_ok && digits_ok && res.pad == '0
    && res.soundex_value == VALUE_W'(CHAR_W'(res.first_letter) - ASCII_UPPER_A) * WEIGHT_LETTER
      + VALUE_W'(res.digit_one) * WEIGHT_ONE + VALUE_W'(res.digit_two) * WEIGHT_TWO
      + VALUE_W'(res.digit_three) + VALUE_W'(1),
    "result value does not match its letter and digits")

endmodule

bind soundex_encoder_core snd_checker u_snd_checker (.*);

`default_nettype wire

// ===== sim/soundex_encoder_core_checker.sv =====
`default_nettype none

module soundex_encoder_core_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [snd_pkg::CHAR_W-1:0] s_axis_tdata,   // [7:0] character
  input  logic                      s_axis_tlast,   // end_of_name
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [snd_pkg::OUT_W-1:0] m_axis_tdata,   // [13:0] soundex_value,
                                                    // [20:14] first_letter,
                                                    // [23:21] digit_one,
                                                    // [26:24] digit_two,
                                                    // [29:27] digit_three, [31:30] 0
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);

  import snd_pkg::*;

  logic                 name_started;
  index_t               lead_index;
  code_t                last_code;
  logic [COUNT_W-1:0]   digits_taken;
  code_t                taken_digits [DIGITS];
  result_t              code_q [$];
  int                   fails = 0;
  int                   checked_n = 0;

  function automatic code_t letter_group(input logic [7:0] up);
    code_t grp;
    case (up)
      "B", "F", "P", "V":                     grp = 3'd1;
      "C", "G", "J", "K", "Q", "S", "X", "Z": grp = 3'd2;
      "D", "T":                               grp = 3'd3;
      "L":                                    grp = 3'd4;
      "M", "N":                               grp = 3'd5;
      "R":                                    grp = 3'd6;
      default:                                grp = 3'd0;
    endcase
    return grp;
  endfunction

  task automatic clear_name();
    name_started = 1'b0;
    lead_index   = '0;
    last_code    = '0;
    digits_taken = '0;
    for (int i = 0; i < DIGITS; i++) taken_digits[i] = '0;
  endtask

  task automatic absorb_char(input logic [7:0] ch, input logic eon);
    logic [7:0]  up;
    code_t       grp;
    result_t     want;
    int unsigned packed_value;
    if (eon) begin
      want = '0;
      if (name_started) begin
        packed_value = lead_index * GROUPS * GROUPS * GROUPS
                     + taken_digits[0] * GROUPS * GROUPS
                     + taken_digits[1] * GROUPS
                     + taken_digits[2] + 1;
        want.soundex_value = packed_value[VALUE_W-1:0];
        want.first_letter  = LETTER_W'(ASCII_UPPER_A + lead_index);
        want.digit_one     = taken_digits[0];
        want.digit_two     = taken_digits[1];
        want.digit_three   = taken_digits[2];
      end
      code_q.push_back(want);
      clear_name();
    end else begin
      up = ch;
      if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) up = ch - (ASCII_LOWER_A - ASCII_UPPER_A);
      if (up >= ASCII_UPPER_A && up <= ASCII_UPPER_Z) begin
        grp = letter_group(up);
        if (!name_started) begin
          name_started = 1'b1;
          lead_index   = index_t'(up - ASCII_UPPER_A);
          last_code    = grp;
        end else if (digits_taken < DIGITS) begin
          if (grp != 3'd0 && grp != last_code) begin
            taken_digits[digits_taken] = grp;
            digits_taken = digits_taken + 1'b1;
          end
          last_code = grp;
        end
      end
    end
  endtask

  task automatic check_code(input result_t got);
    result_t want;
    if (code_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result: value=%0d letter=%0d digits=%0d%0d%0d",
                 got.soundex_value, got.first_letter, got.digit_one, got.digit_two,
                 got.digit_three);
    end else begin
      want = code_q.pop_front();
      checked_n++;
      if (got.soundex_value !== want.soundex_value || got.first_letter !== want.first_letter ||
          got.digit_one !== want.digit_one || got.digit_two !== want.digit_two ||
          got.digit_three !== want.digit_three || got.pad !== want.pad) begin
        fails++;
        if (fails <= 10)
          $display("mismatch at result %0d: exp value=%0d letter=%0d digits=%0d%0d%0d pad=%0d",
                   checked_n, want.soundex_value, want.first_letter, want.digit_one,
                   want.digit_two, want.digit_three, want.pad,
                   " got value=%0d letter=%0d digits=%0d%0d%0d pad=%0d",
                   got.soundex_value, got.first_letter, got.digit_one, got.digit_two,
                   got.digit_three, got.pad);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_name();
      code_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_code(result_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) absorb_char(s_axis_tdata, s_axis_tlast);
    end
    fail_count <= fails;
    pending    <= code_q.size();
    checked    <= checked_n;
  end

endmodule

`default_nettype wire

// ===== sim/soundex_encoder_core_tb.sv =====
`default_nettype none

module soundex_encoder_core_tb;

  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG  = 3000;
  localparam int TAIL      = 8;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_valid = 1'b0;
  logic [snd_pkg::CHAR_W-1:0] s_data = '0;
  logic                      s_last = 1'b0;
  logic                      m_ready = 1'b0;
  wire                       s_ready;
  wire                       m_valid;
  wire  [snd_pkg::OUT_W-1:0] m_data;

  int fail_count;
  int pending;
  int checked;
  int tx_idle = 12;
  int rx_idle = 77;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int n_items = 0;
  int n_names = 0;
  int quiet_cycles = 0;

  soundex_encoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  soundex_encoder_core_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[soundex_encoder_core] ERROR");
    $finish;
  end

  task automatic send_item(input logic [7:0] ch, input logic eon);
    while ($urandom_range(99) < tx_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= eon;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
  endtask

  task automatic end_name(input logic [7:0] ch);
    send_item(ch, 1'b1);
    n_names++;
  endtask

  task automatic send_random_name();
    int         len;
    bit         junk;
    logic [7:0] ch;
    junk = ($urandom_range(9) == 0);
    len  = $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if (junk || $urandom_range(7) == 0) begin
        ch = 8'($urandom_range(255));
      end else begin
        ch = 8'h41 + 8'($urandom_range(25));
        if ($urandom_range(1)) ch = ch + 8'h20;
      end
      send_item(ch, 1'b0);
    end
    end_name(8'($urandom_range(255)));
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    end_name(8'h00);
    send_item(8'hFF, 1'b0);
    send_item("@", 1'b0);
    end_name("Z");
    send_item("z", 1'b0);
    end_name(8'hFF);
    send_text("A");
    send_item(8'h80, 1'b0);
    send_text("bHB{tlx");
    end_name("q");
    send_text("ZrerEr");
    end_name(8'h7F);
    drain();

    while (n_items < 240) send_random_name();
    drain();
    tx_idle = 77;
    rx_idle <= 12;
    while (n_items < 450) send_random_name();
    drain();
    tx_idle = 0;
    rx_idle <= 0;
    hold_req <= hold_req + 1;
    while (n_items < 560) send_random_name();
    drain();
    while (n_items < 660) send_random_name();
    drain();
    repeat (TAIL) @(posedge clk);

    $display("covered %0d items in %0d names, %0d results compared", n_items, n_names, checked);
    $display("pacing: slow receiver, slow sender, none, plus one long receiver hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("[soundex_encoder_core] OK");
    end else begin
      $display("[soundex_encoder_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
